FILE: sv/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared constants, control bundles and a width helper for the vertex
// transform / perspective divide block.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 4;
  localparam int NUM_AXES = 3;

  // item kind carried in tuser
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_XFORM = 1'b1;

  // Width of an exact column sum: three full products plus the shifted
  // translation term, with one bit of headroom and one sign bit.
  function automatic int sum_width(int w, int f);
    int prod_bits;
    int trans_bits;
    prod_bits  = 2 * w;
    trans_bits = w - 1 + f;
    return ((prod_bits > trans_bits) ? prod_bits : trans_bits) + 2;
  endfunction

  // MAC lane control: step 0 seeds the accumulator with the translation row
  typedef struct packed {
    logic       active;
    logic [1:0] step;
  } mac_ctrl_t;

  // divider lane control
  typedef struct packed {
    logic prep;  // take magnitude and sign of the column sum
    logic init;  // overflow check, seed remainder
    logic iter;  // one quotient bit
  } div_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/vtpd_mac_lane.sv
// ----------------------------------------------------------------------------
// vtpd_mac_lane
// One matrix column: holds its four entries and accumulates the dot product
// of (x, y, z, 1) with the column, one product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_mac_lane #(
  parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = vtpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              wr_en_i,
  input  wire logic [1:0]                                        wr_row_i,
  input  wire logic [COORD_WIDTH-1:0]                            wr_val_i,
  input  wire logic [vtpd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]    point_i,
  input  wire vtpd_pkg::mac_ctrl_t                               ctrl_i,
  output logic signed [vtpd_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0] sum_o
);
  import vtpd_pkg::*;

  localparam int SUM_W  = sum_width(COORD_WIDTH, FRAC_BITS);
  localparam int PROD_W = 2 * COORD_WIDTH;

  logic [COORD_WIDTH-1:0]        col_q [NUM_ROWS];
  logic signed [COORD_WIDTH-1:0] mul_a;
  logic signed [COORD_WIDTH-1:0] mul_b;
  logic signed [2*COORD_WIDTH-1:0] prod_q;
  logic signed [SUM_W-1:0]       trans;
  logic signed [SUM_W-1:0]       acc_d;
  logic signed [SUM_W-1:0]       acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        col_q[r] <= '0;
      end
    end else if (wr_en_i) begin
      col_q[wr_row_i] <= wr_val_i;
    end
  end

  always_comb begin
    case (ctrl_i.step)
      2'd0:    mul_a = point_i[0];
      2'd1:    mul_a = point_i[1];
      2'd2:    mul_a = point_i[2];
      default: mul_a = point_i[0];  // last step only drains the product
    endcase
    mul_b = col_q[ctrl_i.step];
    trans = SUM_W'($signed(col_q[NUM_ROWS-1])) <<< FRAC_BITS;
    acc_d = (ctrl_i.step == 2'd0) ? trans : acc_q + SUM_W'(prod_q);
  end

  // full signed product of the two coordinate-wide operands
  always_ff @(posedge clk_i) begin
    if (ctrl_i.active) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      acc_q  <= acc_d;
    end
  end

  assign sum_o = acc_q;

endmodule

`default_nettype wire

FILE: sv/vtpd_div_lane.sv
// ----------------------------------------------------------------------------
// vtpd_div_lane
// Restoring divider for one coordinate: (|s| << FRAC_BITS) / |w|, one
// quotient bit per cycle, with an up-front overflow check. When w is zero
// the lane passes |s| >> FRAC_BITS instead.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_div_lane #(
  parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = vtpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                                    clk_i,
  input  wire vtpd_pkg::div_ctrl_t                                     ctrl_i,
  input  wire logic signed [vtpd_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0] sum_i,
  input  wire logic [vtpd_pkg::sum_width(COORD_WIDTH, FRAC_BITS)-1:0]  wmag_i,
  input  wire logic                                                    wz_i,
  input  wire logic                                                    wneg_i,
  output logic [COORD_WIDTH:0]                                         quo_o,
  output logic                                                         ovf_o,
  output logic                                                         neg_o
);
  import vtpd_pkg::*;

  localparam int SUM_W = sum_width(COORD_WIDTH, FRAC_BITS);
  localparam int NUM_W = SUM_W + FRAC_BITS;
  localparam int QW    = COORD_WIDTH + 1;

  logic [SUM_W-1:0] smag_q;
  logic             sneg_q;
  logic [SUM_W-1:0] rem_q;
  logic [QW-1:0]    nlo_q;
  logic [QW-1:0]    quo_q;
  logic             ovf_q;
  logic             neg_q;
  logic             bypass_q;

  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] num_hi;
  logic [SUM_W-1:0] shifted;
  logic             ovf_init;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;
  logic             take;

  always_comb begin
    num      = {smag_q, {FRAC_BITS{1'b0}}};
    num_hi   = num >> QW;
    shifted  = smag_q >> FRAC_BITS;
    ovf_init = wz_i ? (|(smag_q >> (FRAC_BITS + QW))) : (num_hi >= NUM_W'(wmag_i));
    trial    = {rem_q, nlo_q[QW-1]};
    diff     = trial - {1'b0, wmag_i};
    take     = (trial >= {1'b0, wmag_i});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prep) begin
      sneg_q <= sum_i[SUM_W-1];
      smag_q <= sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    end
    if (ctrl_i.init) begin
      ovf_q    <= ovf_init;
      bypass_q <= wz_i;
      neg_q    <= wz_i ? sneg_q : (sneg_q ^ wneg_i);
      rem_q    <= num_hi[SUM_W-1:0];  // below |w| unless overflow
      nlo_q    <= num[QW-1:0];
      quo_q    <= wz_i ? shifted[QW-1:0] : '0;
    end else if (ctrl_i.iter && !bypass_q) begin
      rem_q <= take ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quo_q <= {quo_q[QW-2:0], take};
      nlo_q <= {nlo_q[QW-2:0], 1'b0};
    end
  end

  assign quo_o = quo_q;
  assign ovf_o = ovf_q;
  assign neg_o = neg_q;

endmodule

`default_nettype wire

FILE: sv/vtpd_merge.sv
// ----------------------------------------------------------------------------
// vtpd_merge
// Merges the divider lanes: applies signs and saturates each magnitude to
// the signed coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_merge #(
  parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF
) (
  input  wire logic [vtpd_pkg::NUM_AXES-1:0][COORD_WIDTH:0]   quo_i,
  input  wire logic [vtpd_pkg::NUM_AXES-1:0]                  ovf_i,
  input  wire logic [vtpd_pkg::NUM_AXES-1:0]                  neg_i,
  output logic [vtpd_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]      coord_o
);
  import vtpd_pkg::*;

  localparam logic [COORD_WIDTH:0]   LIM     = (COORD_WIDTH+1)'(1) << (COORD_WIDTH - 1);
  localparam logic [COORD_WIDTH-1:0] MAX_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [NUM_AXES-1:0][COORD_WIDTH:0] negq;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      negq[a] = '0 - quo_i[a];
      if (neg_i[a]) begin
        coord_o[a] = (ovf_i[a] || quo_i[a] > LIM) ? MIN_NEG : negq[a][COORD_WIDTH-1:0];
      end else begin
        coord_o[a] = (ovf_i[a] || quo_i[a] >= LIM) ? MAX_POS : quo_i[a][COORD_WIDTH-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/vertex_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// 4x4 homogeneous point transform with perspective divide, signed fixed
// point (Q16.16 at default parameters), saturating results.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   row, col, entry_value, point_x/y/z, pad     action
//  m_axis    out  out_x, out_y, out_z                         w_zero
//
//  Load items (action = 0) write one matrix entry; the block stays idle and
//  can take the next item. Transform items do not overlap: input is held off
//  until the done state has loaded the result register. A transform runs
//  4 MAC steps, the prep and init setup states, then the restoring dividers
//  run one quotient bit per cycle over COORD_WIDTH + 1 bits; the done state
//  loads the result register and the idle state takes the next item.
//  Reset clears the matrix to zero, empties the result register and idles.
//  A finished result waits in the final stage while the result register
//  still holds an untaken item; input is not taken during that wait.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_perspective_divide #(
  parameter  int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF,
  parameter  int FRAC_BITS   = vtpd_pkg::FRAC_BITS_DEF,
  localparam int IN_DW       = ((4 * COORD_WIDTH + 4 + 7) / 8) * 8,
  localparam int OUT_DW      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // slave side
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_DW-1:0]  s_axis_tdata,   // row, col, entry_value, point_x, point_y, point_z
  input  wire logic              s_axis_tuser,   // action
  // master side
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_DW-1:0]      m_axis_tdata,   // out_x, out_y, out_z
  output logic                   m_axis_tuser    // w_zero
);
  import vtpd_pkg::*;

  localparam int SUM_W = sum_width(COORD_WIDTH, FRAC_BITS);
  localparam int CNT_W = $clog2(COORD_WIDTH + 1);

  // tdata field offsets
  localparam int ROW_LSB   = 0;
  localparam int COL_LSB   = 2;
  localparam int ENTRY_LSB = 4;
  localparam int PX_LSB    = ENTRY_LSB + COORD_WIDTH;

  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(NUM_ROWS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(COORD_WIDTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_INIT = 3'd3;
  localparam logic [2:0] ST_ITER = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic       in_acc;
  logic       in_load;
  logic [1:0] in_row;
  logic [1:0] in_col;

  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] point_q;
  logic [NUM_COLS-1:0]                  wr_en;
  logic [NUM_COLS-1:0][SUM_W-1:0]       sums;

  mac_ctrl_t mac_ctrl;
  div_ctrl_t div_ctrl;

  // w (column 3) summary, held through the divide
  logic             wz_q;
  logic             wneg_q;
  logic [SUM_W-1:0] wmag_q;
  logic signed [SUM_W-1:0] wsum;

  logic [NUM_AXES-1:0][COORD_WIDTH:0]   quo;
  logic [NUM_AXES-1:0]                  ovf;
  logic [NUM_AXES-1:0]                  neg;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] coord;

  // result register
  logic              out_valid_q;
  logic [OUT_DW-1:0] out_data_q;
  logic              out_user_q;
  logic              out_load;

  // ---- input side ----
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_load       = in_acc && (s_axis_tuser == ACT_LOAD);
  assign in_row        = s_axis_tdata[ROW_LSB +: 2];
  assign in_col        = s_axis_tdata[COL_LSB +: 2];

  always_comb begin
    for (int j = 0; j < NUM_COLS; j++) begin
      wr_en[j] = in_load && (in_col == 2'(j));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == ACT_XFORM) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        point_q[a] <= s_axis_tdata[PX_LSB + a * COORD_WIDTH +: COORD_WIDTH];
      end
    end
  end

  // ---- sequencer ----
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser == ACT_XFORM) begin
          state_d = ST_MAC;
          cnt_d   = '0;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MAC_LAST) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: state_d = ST_INIT;
      ST_INIT: begin
        state_d = ST_ITER;
        cnt_d   = '0;
      end
      ST_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    mac_ctrl.active = (state_q == ST_MAC);
    mac_ctrl.step   = cnt_q[1:0];
    div_ctrl.prep   = (state_q == ST_PREP);
    div_ctrl.init   = (state_q == ST_INIT);
    div_ctrl.iter   = (state_q == ST_ITER);
  end

  // ---- column lanes ----
  for (genvar j = 0; j < NUM_COLS; j++) begin : g_mac
    vtpd_mac_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en[j]),
      .wr_row_i (in_row),
      .wr_val_i (s_axis_tdata[ENTRY_LSB +: COORD_WIDTH]),
      .point_i  (point_q),
      .ctrl_i   (mac_ctrl),
      .sum_o    (sums[j])
    );
  end

  // w summary: zero test, sign and magnitude of column 3
  assign wsum = sums[NUM_COLS-1];

  always_ff @(posedge clk_i) begin
    if (div_ctrl.prep) begin
      wz_q   <= (wsum == '0);
      wneg_q <= wsum[SUM_W-1];
      wmag_q <= wsum[SUM_W-1] ? SUM_W'(-wsum) : SUM_W'(wsum);
    end
  end

  // ---- divider lanes, one per output coordinate ----
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_div
    vtpd_div_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_div (
      .clk_i  (clk_i),
      .ctrl_i (div_ctrl),
      .sum_i  (sums[a]),
      .wmag_i (wmag_q),
      .wz_i   (wz_q),
      .wneg_i (wneg_q),
      .quo_o  (quo[a]),
      .ovf_o  (ovf[a]),
      .neg_o  (neg[a])
    );
  end

  vtpd_merge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge (
    .quo_i   (quo),
    .ovf_i   (ovf),
    .neg_i   (neg),
    .coord_o (coord)
  );

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // coordinates in the low bits, zero pad above
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OUT_DW'(coord);
      out_user_q <= wz_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

FILE: sv/vtpd_checker.sv
// ----------------------------------------------------------------------------
// vtpd_checker
// Port-level checks for the vertex transform block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_checker #(
  parameter  int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF,
  localparam int OUT_DW      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              s_axis_tuser,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [OUT_DW-1:0] m_axis_tdata,
  input wire logic              m_axis_tuser
);
  import vtpd_pkg::*;

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // a transform occupies the block: no item taken right behind it
  a_xform_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_XFORM |=> !s_axis_tready)
    else $error("input taken during a transform");

  // a load item never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_LOAD && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("result appeared after a load item");

endmodule

bind vertex_transform_perspective_divide vtpd_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_vtpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for the vertex transform / perspective divide block.
// Drives matrix loads and point transforms, predicts each projected vertex
// from a local copy of the matrix, and compares results in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int CW        = vtpd_pkg::COORD_WIDTH_DEF;
  localparam int FRAC      = vtpd_pkg::FRAC_BITS_DEF;
  localparam int IN_DW     = ((4 * CW + 4 + 7) / 8) * 8;
  localparam int OUT_DW    = ((3 * CW + 7) / 8) * 8;
  localparam int RAND_PER_PHASE = 500;
  // drain margin with room for stalls on both sides
  localparam int DRAIN_CYCLES   = 4 * (CW + 9);
  localparam int CYCLE_LIMIT    = 1_000_000;

  // Q16.16 constants used by the directed part
  localparam logic [31:0] ONE     = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] MAX_Q   = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_Q   = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        w_zero;
  } vertex_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the matrix, predicts one vertex per transform item and
  // checks results against the oldest outstanding prediction.
  // --------------------------------------------------------------------------
  class vertex_scoreboard;
    logic [31:0] mat [4][4];
    vertex_t     expected_q [$];
    int          n_loads;
    int          n_points;
    int          n_checked;
    int          n_wzero;
    int          n_sat;
    int          errors;

    function new();
      foreach (mat[r, c]) mat[r][c] = '0;
      n_loads   = 0;
      n_points  = 0;
      n_checked = 0;
      n_wzero   = 0;
      n_sat     = 0;
      errors    = 0;
    endfunction

    // exact row-vector product, divide by w (or not), saturate
    function vertex_t project_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      logic signed [127:0] pt [3];
      logic signed [127:0] sum [4];
      logic signed [127:0] trans;
      logic [127:0]        wmag;
      logic [127:0]        smag;
      logic [127:0]        quo;
      logic                wz;
      logic                wneg;
      logic                sneg;
      logic                rneg;
      logic [31:0]         axis [3];
      vertex_t             res;
      pt[0] = $signed(px);
      pt[1] = $signed(py);
      pt[2] = $signed(pz);
      for (int j = 0; j < 4; j++) begin
        trans  = $signed(mat[3][j]);
        sum[j] = pt[0] * $signed(mat[0][j]) + pt[1] * $signed(mat[1][j])
               + pt[2] * $signed(mat[2][j]) + (trans <<< FRAC);
      end
      wz   = (sum[3] == 0);
      wneg = sum[3][127];
      wmag = wneg ? -sum[3] : sum[3];
      for (int j = 0; j < 3; j++) begin
        sneg = sum[j][127];
        smag = sneg ? -sum[j] : sum[j];
        if (wz) begin
          quo  = smag >> FRAC;
          rneg = sneg;
        end else begin
          quo  = (smag << FRAC) / wmag;
          rneg = sneg ^ wneg;
        end
        // clamp magnitude to the signed 32-bit range
        if (rneg) begin
          if (quo > 128'h8000_0000) begin
            axis[j] = MIN_Q;
            n_sat++;
          end else begin
            axis[j] = ~quo[31:0] + 32'd1;
          end
        end else begin
          if (quo > 128'h7FFF_FFFF) begin
            axis[j] = MAX_Q;
            n_sat++;
          end else begin
            axis[j] = quo[31:0];
          end
        end
      end
      res.x      = axis[0];
      res.y      = axis[1];
      res.z      = axis[2];
      res.w_zero = wz;
      return res;
    endfunction

    function void note_input(logic act, logic [1:0] r, logic [1:0] c, logic [31:0] v,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      if (act == vtpd_pkg::ACT_LOAD) begin
        mat[r][c] = v;
        n_loads++;
      end else begin
        expected_q.push_back(project_point(px, py, pz));
        n_points++;
      end
    endfunction

    function void check_result(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                               logic gw);
      vertex_t exp_v;
      if (expected_q.size() == 0) begin
        $error("unexpected result: x=%h y=%h z=%h w_zero=%b", gx, gy, gz, gw);
        errors++;
        return;
      end
      exp_v = expected_q.pop_front();
      n_checked++;
      if (exp_v.w_zero) n_wzero++;
      if (gx !== exp_v.x) begin
        $error("out_x: expected %h, got %h", exp_v.x, gx);
        errors++;
      end
      if (gy !== exp_v.y) begin
        $error("out_y: expected %h, got %h", exp_v.y, gy);
        errors++;
      end
      if (gz !== exp_v.z) begin
        $error("out_z: expected %h, got %h", exp_v.z, gz);
        errors++;
      end
      if (gw !== exp_v.w_zero) begin
        $error("w_zero: expected %b, got %b", exp_v.w_zero, gw);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_DW-1:0]  s_axis_tdata  = '0;  // row, col, entry_value, point_x, point_y, point_z
  logic              s_axis_tuser  = 1'b0; // action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;         // out_x, out_y, out_z
  logic              m_axis_tuser;         // w_zero

  vertex_transform_perspective_divide u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  vertex_scoreboard sb;

  // per-phase idle odds, percent of cycles
  int send_idle_tbl  [4] = '{0, 69, 0, 23};
  int recv_stall_tbl [4] = '{0, 0, 69, 23};
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or loses a result.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $error("watchdog expired after %0d cycles", CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Result side: values seen at the edge are the pre-edge ones, so the
  // handshake test and the data are consistent. tready is re-rolled each edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                      m_axis_tuser);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Present one item and hold it until accepted. Called at a rising edge; on
  // return the item was taken at the current edge and tvalid is still high,
  // so a back-to-back item just overwrites data without dropping tvalid.
  task automatic push_item(input logic act, input logic [1:0] r, input logic [1:0] c,
                           input logic [31:0] v, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0, pz, py, px, v, c, r};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(act, r, c, v, px, py, pz);
  endtask

  // point fields are don't-care on a load; randomize them anyway
  task automatic send_load(input logic [1:0] r, input logic [1:0] c, input logic [31:0] v);
    push_item(vtpd_pkg::ACT_LOAD, r, c, v, $urandom, $urandom, $urandom);
  endtask

  // row, col and entry value are don't-care on a transform
  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz);
    push_item(vtpd_pkg::ACT_XFORM, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
              $urandom, px, py, pz);
  endtask

  // Mix of magnitudes: full-range words mostly saturate, the smaller classes
  // keep the divide in range so the quotient bits actually get exercised.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4, 5: v = 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;  // +/-8.0
      6:       v = 32'($urandom_range(0, 511)) - 32'd256;                 // few lsbs
      7: begin
        case ($urandom_range(0, 6))
          0:       v = MAX_Q;
          1:       v = MIN_Q;
          2:       v = '0;
          3:       v = 32'd1;
          4:       v = 32'hFFFF_FFFF;
          5:       v = ONE;
          default: v = NEG_ONE;
        endcase
      end
      default: v = 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;  // +/-256.0
    endcase
    return v;
  endfunction

  initial begin
    logic [1:0] r;
    logic [1:0] c;
    sb = new();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    // matrix clears at reset: w is zero, nothing to divide
    send_point(ONE, 32'h0002_0000, 32'h0003_0000);
    // identity
    send_load(2'd0, 2'd0, ONE);
    send_load(2'd1, 2'd1, ONE);
    send_load(2'd2, 2'd2, ONE);
    send_load(2'd3, 2'd3, ONE);
    send_point(32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000);
    send_point(MAX_Q, MIN_Q, 32'h0000_0000);
    // perspective: w = z + 1
    send_load(2'd2, 2'd3, ONE);
    send_point(32'h0002_0000, 32'h0004_0000, ONE);
    // w exactly zero: undivided sums come out with the flag
    send_point(32'h0003_0000, 32'hFFFB_0000, NEG_ONE);
    // w of one lsb: divide runs and saturates both ways
    send_point(ONE, NEG_ONE, 32'hFFFF_0001);
    // negative w flips the signs
    send_point(32'h0002_0000, 32'hFFFE_0000, 32'hFFFD_0000);
    // translation row at the extremes
    send_load(2'd3, 2'd0, MAX_Q);
    send_load(2'd3, 2'd1, MIN_Q);
    send_point(32'h0, 32'h0, 32'h0);
    // largest product
    send_load(2'd0, 2'd0, MIN_Q);
    send_point(MIN_Q, ONE, 32'h0);
    // negative translation in the w column: w = z - 1
    send_load(2'd3, 2'd3, NEG_ONE);
    send_point(MAX_Q, MAX_Q, MAX_Q);

    // ---- random, one phase per idle pattern ----
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_idle_tbl[phase];
      recv_stall_pct = recv_stall_tbl[phase];
      repeat (RAND_PER_PHASE) begin
        if ($urandom_range(0, 99) < 30) begin
          r = 2'($urandom_range(0, 3));
          c = 2'($urandom_range(0, 3));
          // zeros in the w column often enough that w = 0 keeps turning up
          if (c == 2'd3 && $urandom_range(0, 4) < 2) send_load(r, c, 32'h0);
          else send_load(r, c, pick_value());
        end else begin
          send_point(pick_value(), pick_value(), pick_value());
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the receiver keep stalling while the tail drains
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d matrix loads, %0d transforms, %0d vertices checked",
             sb.n_loads, sb.n_points, sb.n_checked);
    $display("summary: %0d with w zero, %0d saturated axes, 4 flow-control patterns",
             sb.n_wzero, sb.n_sat);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
